// ===== sv/assert_macros.svh =====
// assertion macros shared by the sampler rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the same cycle
`define BTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/bts_pkg.sv =====
// shared types and constants of the bilinear texture sampler
// no dependencies; used by the texel banks, the top level and the testbench
`default_nettype none

package bts_pkg;

  localparam int unsigned StoreAw = 16;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned SideW   = 9;

  localparam logic [CoordW-1:0] CoordMin = 16'd1;
  localparam logic [CoordW-1:0] CoordMax = 16'd65534;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } bts_op_e;

  typedef enum logic [0:0] {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } bts_reg_e;

  // index 2 red, 1 green, 0 blue
  typedef logic [2:0][7:0] texel_t;

  typedef logic [StoreAw-1:0] store_addr_t;

  // request from the address stage to the texel banks
  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [3:0][StoreAw-1:0] addr;
    texel_t                wdata;
  } store_req_t;

endpackage

`default_nettype wire

// ===== sv/bts_if.sv =====
// valid/ready channels of the sampler: input items and result items
// depends on nothing but plain logic types
`default_nettype none

interface bts_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] texel_index;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [15:0] u_coord;
  logic [15:0] v_coord;

  modport source (
    output valid, op, texel_index, red_in, green_in, blue_in, u_coord, v_coord,
    input  ready
  );
  modport sink (
    input  valid, op, texel_index, red_in, green_in, blue_in, u_coord, v_coord,
    output ready
  );
endinterface

interface bts_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/bilinear_texture_sampler.sv =====
// Bilinear texture sampler, five-stage pipeline.
// Input channel item_i carries one beat per item: op = write stores the
// RGB texel at texel_index (row-major, stride tex_width), op = sample
// filters the texture at Q0.16 coordinates u_coord, v_coord.
// Output channel result_o carries one beat per sample item, channels in
// byte scale with 8 fraction bits; write items give no beat.
// Stages: clamp and scale, corner address, texel fetch, y pass, x pass.
// A sample result passes the stage registers in that order to result_o.
// One item enters per cycle unless the full pipeline is stalled; the
// four corner fetches run in parallel on four copies of the texel store.
// Each stage advances on its own, so bubbles close up and item_i stays
// ready while any stage is empty, even with the receiver stalling.
// The user must write tex_width and tex_height on cfg_*_i only while
// idle; the block does not enforce it. Values are saturated to 2..MAX_SIDE
// (at most 511). Reset empties the pipeline and sets both sides to 256
// (capped at MAX_SIDE); texel contents are undefined until written.
// depends on bts_pkg, bts_if, bts_texel_banks and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bilinear_texture_sampler #(
  parameter int unsigned MAX_SIDE  = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [8:0] cfg_data_i,
  bts_item_if.sink        item_i,
  bts_result_if.source    result_o
);

  localparam int unsigned SW  = bts_pkg::SideW;
  localparam int unsigned AW  = bts_pkg::StoreAw;
  localparam int unsigned PxW = bts_pkg::CoordW + SW;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned LW  = F + 8;       // y pass result
  localparam int unsigned LPW = F + 9;       // y pass product width
  localparam int unsigned MW  = 2 * F + 9;   // x pass product width
  localparam logic [SW-1:0] SideCap   = SW'(MAX_SIDE > 511 ? 511 : MAX_SIDE);
  localparam logic [SW-1:0] SideReset = SW'(MAX_SIDE < 256 ? MAX_SIDE : 256);
  localparam logic [F:0]    OneW      = (F+1)'(1) << F;

  function automatic logic [SW-1:0] sat_side(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s < SW'(2))        r = SW'(2);
    else if (s > SideCap)  r = SideCap;
    else                   r = s;
    return r;
  endfunction

  function automatic logic [15:0] clamp_coord(input logic [15:0] c);
    logic [15:0] r;
    if (c < bts_pkg::CoordMin)      r = bts_pkg::CoordMin;
    else if (c > bts_pkg::CoordMax) r = bts_pkg::CoordMax;
    else                            r = c;
    return r;
  endfunction

  // 16-bit fraction taken to F bits
  function automatic logic [F-1:0] weight(input logic [15:0] f16);
    logic [39:0] ext;
    ext = {f16, 24'd0};
    return F'(ext >> (40 - F));
  endfunction

  // ---------------- configuration ----------------
  logic [SW-1:0] side_w_q, side_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_w_q <= SideReset;
      side_h_q <= SideReset;
    end else if (cfg_we_i) begin
      unique case (bts_pkg::bts_reg_e'(cfg_index_i))
        bts_pkg::REG_TEX_WIDTH:  side_w_q <= sat_side(cfg_data_i);
        bts_pkg::REG_TEX_HEIGHT: side_h_q <= sat_side(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------- stage enables ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || result_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign item_i.ready = en1;

  // ---------------- stage 1: clamp and scale ----------------
  logic           op1_q;
  logic [AW-1:0]  idx1_q;
  bts_pkg::texel_t wd1_q;
  logic [PxW-1:0] px1_q, py1_q;
  logic [PxW-1:0] px_d, py_d;
  logic [15:0]    cu, cv;

  assign cu   = clamp_coord(item_i.u_coord);
  assign cv   = clamp_coord(item_i.v_coord);
  assign px_d = {{SW{1'b0}}, cu} * {16'd0, side_w_q - SW'(1)};
  assign py_d = {{SW{1'b0}}, cv} * {16'd0, side_h_q - SW'(1)};

  always_ff @(posedge clk_i) begin
    if (en1 && item_i.valid) begin
      op1_q  <= item_i.op;
      idx1_q <= item_i.texel_index;
      wd1_q  <= {item_i.red_in, item_i.green_in, item_i.blue_in};
      px1_q  <= px_d;
      py1_q  <= py_d;
    end
  end

  // ---------------- stage 2: corner addresses and weights ----------------
  logic [SW-1:0]         xi1, yi1;
  logic [2*SW-1:0]       yw;
  logic [AW-1:0]         xi16, xw16, x116, xw116;
  logic [3:0][AW-1:0]    addr_d;
  logic [3:0][AW-1:0]    addr2_q;
  logic                  op2_q;
  bts_pkg::texel_t       wd2_q;
  logic [F-1:0]          fx2_q, fy2_q;
  logic [F:0]            omfx2_q, omfy2_q;
  logic [F-1:0]          fx_d, fy_d;

  assign xi1   = px1_q[PxW-1:16];
  assign yi1   = py1_q[PxW-1:16];
  assign yw    = {{SW{1'b0}}, yi1} * {{SW{1'b0}}, side_w_q};
  assign xi16  = AW'(xi1);
  assign xw16  = xi16 + AW'(side_w_q);
  assign x116  = xi16 + AW'(1);
  assign xw116 = xw16 + AW'(1);
  assign fx_d  = weight(px1_q[15:0]);
  assign fy_d  = weight(py1_q[15:0]);

  always_comb begin
    if (bts_pkg::bts_op_e'(op1_q) == bts_pkg::OP_WRITE) begin
      addr_d    = '0;
      addr_d[0] = idx1_q;
    end else begin
      addr_d[0] = yw[AW-1:0] + xi16;    // (x, y)
      addr_d[1] = yw[AW-1:0] + xw16;    // (x, y+1)
      addr_d[2] = yw[AW-1:0] + xw116;   // (x+1, y+1)
      addr_d[3] = yw[AW-1:0] + x116;    // (x+1, y)
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      op2_q   <= op1_q;
      wd2_q   <= wd1_q;
      addr2_q <= addr_d;
      fx2_q   <= fx_d;
      fy2_q   <= fy_d;
      omfx2_q <= OneW - {1'b0, fx_d};
      omfy2_q <= OneW - {1'b0, fy_d};
    end
  end

  // ---------------- stage 3: texel fetch ----------------
  bts_pkg::store_req_t req;
  logic [3:0][23:0]    tex3;
  logic                sample2;
  logic [F-1:0]        fx3_q, fy3_q;
  logic [F:0]          omfx3_q, omfy3_q;

  assign sample2    = bts_pkg::bts_op_e'(op2_q) == bts_pkg::OP_SAMPLE;
  assign req.rd_en  = en3 && v2_q && sample2;
  assign req.wr_en  = en3 && v2_q && !sample2;
  assign req.addr   = addr2_q;
  assign req.wdata  = wd2_q;

  bts_texel_banks u_banks (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (tex3)
  );

  always_ff @(posedge clk_i) begin
    if (req.rd_en) begin
      fx3_q   <= fx2_q;
      fy3_q   <= fy2_q;
      omfx3_q <= omfx2_q;
      omfy3_q <= omfy2_q;
    end
  end

  // ---------------- stage 4: y pass ----------------
  bts_pkg::texel_t     t0, t1, t2, t3;
  logic [2:0][LW-1:0]  left_d, right_d, left4_q, right4_q;
  logic [F-1:0]        fx4_q;
  logic [F:0]          omfx4_q;

  assign t0 = tex3[0];
  assign t1 = tex3[1];
  assign t2 = tex3[2];
  assign t3 = tex3[3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      left_d[k]  = LW'(LPW'(t1[k]) * LPW'(fy3_q) + LPW'(t0[k]) * LPW'(omfy3_q));
      right_d[k] = LW'(LPW'(t2[k]) * LPW'(fy3_q) + LPW'(t3[k]) * LPW'(omfy3_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      left4_q  <= left_d;
      right4_q <= right_d;
      fx4_q    <= fx3_q;
      omfx4_q  <= omfx3_q;
    end
  end

  // ---------------- stage 5: x pass and output register ----------------
  logic [2:0][MW-1:0] mix;
  logic [2:0][15:0]   out5_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix[k] = MW'(right4_q[k]) * MW'(fx4_q) + MW'(left4_q[k]) * MW'(omfx4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      for (int k = 0; k < 3; k++) begin
        out5_q[k] <= mix[k][2*F+7 : 2*F-8];
      end
    end
  end

  assign result_o.valid     = v5_q;
  assign result_o.red_out   = out5_q[2];
  assign result_o.green_out = out5_q[1];
  assign result_o.blue_out  = out5_q[0];

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= item_i.valid;
      if (en2) v2_q <= v1_q;
      // write beats end at the store
      if (en3) v3_q <= v2_q && sample2;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- assertions ----------------
  `BTS_ASSERT_IMPL(a_stall_means_full, clk_i, rst_ni, !item_i.ready,
    v1_q && v2_q && v3_q && v4_q && v5_q && !result_o.ready,
    "input stalled although a stage is empty")
  `BTS_ASSERT_IMPL(a_corner_inside, clk_i, rst_ni,
    v1_q && (bts_pkg::bts_op_e'(op1_q) == bts_pkg::OP_SAMPLE),
    (xi1 + SW'(2) <= side_w_q) && (yi1 + SW'(2) <= side_h_q),
    "corner index leaves the texture")
  `BTS_ASSERT(a_result_from_filter, clk_i, rst_ni,
    $rose(result_o.valid) |-> $past(v4_q),
    "result beat without an item in the y pass stage")

endmodule

`default_nettype wire

// ===== sv/bts_texel_banks.sv =====
// four copies of the texel store, one write port shared, one read port each
// depends on bts_pkg for the request struct and texel type
`default_nettype none

module bts_texel_banks (
  input  wire logic                clk_i,
  input  wire bts_pkg::store_req_t req_i,
  output logic [3:0][23:0]         rdata_o
);

  localparam int unsigned Depth = 1 << bts_pkg::StoreAw;

  logic [23:0] bank0_mem [Depth];
  logic [23:0] bank1_mem [Depth];
  logic [23:0] bank2_mem [Depth];
  logic [23:0] bank3_mem [Depth];

  logic [3:0][23:0] rdata_q;

  // every copy takes the same write so any corner can be read from any copy
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      bank0_mem[req_i.addr[0]] <= req_i.wdata;
      bank1_mem[req_i.addr[0]] <= req_i.wdata;
      bank2_mem[req_i.addr[0]] <= req_i.wdata;
      bank3_mem[req_i.addr[0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q[0] <= bank0_mem[req_i.addr[0]];
      rdata_q[1] <= bank1_mem[req_i.addr[1]];
      rdata_q[2] <= bank2_mem[req_i.addr[2]];
      rdata_q[3] <= bank3_mem[req_i.addr[3]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sim/tb_bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
// testbench for bilinear_texture_sampler: texel loads and filtered samples over several
// texture shapes, checked against an in-bench fixed-point predictor with random idling
// depends on bts_pkg, bts_if.sv and the sampler rtl

module tb_bilinear_texture_sampler;

  localparam int unsigned TexSideMax  = 256;
  localparam int unsigned FracBits    = 16;
  localparam longint unsigned WeightOne = 64'd1 << FracBits;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned ReportMax   = 10;

  // index 2 red, 1 green, 0 blue, as texel_t
  typedef logic [2:0][15:0] filtered_t;

  typedef struct packed {
    bts_pkg::bts_op_e     op;
    bts_pkg::store_addr_t index;
    bts_pkg::texel_t      rgb;
    logic [15:0]          u;
    logic [15:0]          v;
  } tex_cmd_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [8:0] cfg_data_i;

  bts_item_if   item_bus ();
  bts_result_if result_bus ();

  bilinear_texture_sampler #(
    .MAX_SIDE  (TexSideMax),
    .FRAC_BITS (FracBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  // shadow of the texel store and the side registers
  bts_pkg::texel_t shadow_tex [65536];
  bit              tex_written [65536];
  logic [8:0]      width_reg  = 9'd256;
  logic [8:0]      height_reg = 9'd256;

  filtered_t filtered_q [$];
  filtered_t expected_px, got_px;

  int unsigned n_items, n_samples, n_writes, n_checked, n_errors, n_shapes;
  int unsigned idle_cycles, stall_left;
  bit offering, tx_steady, rx_steady, hold_req;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [8:0] clipped_side(logic [8:0] s);
    if (s < 9'd2) return 9'd2;
    if (s > TexSideMax) return 9'(TexSideMax);
    return s;
  endfunction

  function automatic logic [15:0] clamp_coord(logic [15:0] c);
    if (c < bts_pkg::CoordMin) return bts_pkg::CoordMin;
    if (c > bts_pkg::CoordMax) return bts_pkg::CoordMax;
    return c;
  endfunction

  // corners: 0 top-left, 1 bottom-left, 2 bottom-right, 3 top-right
  function automatic void locate_cell(input logic [15:0] u, input logic [15:0] v,
                                      output logic [3:0][15:0] addr,
                                      output logic [15:0] fx, output logic [15:0] fy);
    int unsigned w, h, px, py, xi, yi;
    w  = clipped_side(width_reg);
    h  = clipped_side(height_reg);
    px = clamp_coord(u) * (w - 1);
    py = clamp_coord(v) * (h - 1);
    xi = px >> 16;
    yi = py >> 16;
    fx = 16'(px);
    fy = 16'(py);
    addr[0] = 16'(yi * w + xi);
    addr[1] = 16'((yi + 1) * w + xi);
    addr[2] = 16'((yi + 1) * w + xi + 1);
    addr[3] = 16'(yi * w + xi + 1);
  endfunction

  function automatic filtered_t bilerp(logic [15:0] u, logic [15:0] v);
    logic [3:0][15:0] addr;
    logic [15:0]      fx, fy;
    bts_pkg::texel_t  t [4];
    longint unsigned  left, right, mix;
    filtered_t        res;
    locate_cell(u, v, addr, fx, fy);
    for (int i = 0; i < 4; i++) t[i] = shadow_tex[addr[i]];
    for (int ch = 0; ch < 3; ch++) begin
      left  = 64'(t[1][ch]) * fy + 64'(t[0][ch]) * (WeightOne - fy);
      right = 64'(t[2][ch]) * fy + 64'(t[3][ch]) * (WeightOne - fy);
      mix   = right * fx + left * (WeightOne - fx);
      res[ch] = 16'(mix >> (2 * FracBits - 8));
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rim_coord();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd65534;
      default: return 16'd65535;
    endcase
  endfunction

  // offers one beat and books its effect once it is taken
  task automatic send_cmd(input tex_cmd_t cmd);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      if (offering) begin
        item_bus.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid       <= 1'b1;
    item_bus.op          <= cmd.op;
    item_bus.texel_index <= cmd.index;
    item_bus.red_in      <= cmd.rgb[2];
    item_bus.green_in    <= cmd.rgb[1];
    item_bus.blue_in     <= cmd.rgb[0];
    item_bus.u_coord     <= cmd.u;
    item_bus.v_coord     <= cmd.v;
    offering = 1'b1;
    do @(posedge clk_i); while (!item_bus.ready);
    if (cmd.op == bts_pkg::OP_WRITE) begin
      shadow_tex[cmd.index]  = cmd.rgb;
      tex_written[cmd.index] = 1'b1;
      n_writes++;
    end else begin
      filtered_q.push_back(bilerp(cmd.u, cmd.v));
      n_samples++;
    end
    n_items++;
  endtask

  task automatic write_texel(input bts_pkg::store_addr_t index, input bts_pkg::texel_t rgb);
    tex_cmd_t cmd;
    cmd.op    = bts_pkg::OP_WRITE;
    cmd.index = index;
    cmd.rgb   = rgb;
    cmd.u     = 16'($urandom);
    cmd.v     = 16'($urandom);
    send_cmd(cmd);
  endtask

  // loads any corner not yet written, so no unwritten texel is ever read
  task automatic sample_at(input logic [15:0] u, input logic [15:0] v);
    logic [3:0][15:0] addr;
    logic [15:0]      fx, fy;
    tex_cmd_t         cmd;
    locate_cell(u, v, addr, fx, fy);
    for (int i = 0; i < 4; i++)
      if (!tex_written[addr[i]]) write_texel(addr[i], 24'($urandom));
    cmd.op    = bts_pkg::OP_SAMPLE;
    cmd.index = 16'($urandom);
    cmd.rgb   = 24'($urandom);
    cmd.u     = u;
    cmd.v     = v;
    send_cmd(cmd);
  endtask

  task automatic drain_and_idle();
    if (offering) begin
      item_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (filtered_q.size() != 0) @(posedge clk_i);
    // texel writes give no beat and may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reshape(input logic [8:0] w, input logic [8:0] h);
    drain_and_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= bts_pkg::REG_TEX_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    width_reg = w;
    cfg_index_i <= bts_pkg::REG_TEX_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    height_reg = h;
    cfg_we_i <= 1'b0;
    n_shapes++;
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned first, r, area;
    first = n_items;
    area  = clipped_side(width_reg) * clipped_side(height_reg);
    while (n_items - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) sample_at(rim_coord(), rim_coord());
      else if (r < 50) sample_at(16'($urandom), 16'($urandom));
      else if (r < 80) write_texel(16'($urandom_range(0, area - 1)), 24'($urandom));
      else write_texel(16'($urandom), 24'($urandom));
    end
  endtask

  // default 256 x 256 shape: corners of the store and the coordinate clamps
  task automatic test_reset_shape();
    write_texel(16'd0, 24'h000000);
    write_texel(16'd1, 24'hFFFFFF);
    write_texel(16'd256, 24'hFF00FF);
    write_texel(16'd257, 24'h00FF00);
    write_texel(16'hFEFE, 24'h00FF00);
    write_texel(16'hFEFF, 24'hFF0000);
    write_texel(16'hFFFE, 24'h0000FF);
    write_texel(16'hFFFF, 24'hFFFFFF);
    sample_at(16'd0, 16'd0);
    sample_at(16'd1, 16'd1);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'hFFFE, 16'hFFFE);
    sample_at(16'd0, 16'hFFFF);
  endtask

  task automatic test_tiny_texture();
    reshape(9'd2, 9'd2);
    write_texel(16'd0, 24'hFFFFFF);
    write_texel(16'd1, 24'h000000);
    write_texel(16'd2, 24'h000000);
    write_texel(16'd3, 24'hFFFFFF);
    sample_at(16'd0, 16'd0);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'h8000, 16'h0000);
    sample_at(16'h0000, 16'h8000);
    random_traffic(120);
  endtask

  // sides below, at and above the legal range, plus random shapes
  task automatic test_side_sweep();
    logic [8:0] ws [6];
    logic [8:0] hs [6];
    ws = '{9'd0, 9'd511, 9'd3, 9'd256, 9'd2, 9'd2};
    hs = '{9'd1, 9'd300, 9'd255, 9'd2, 9'd2, 9'd2};
    ws[4] = 9'($urandom_range(2, 256));
    hs[4] = 9'($urandom_range(2, 256));
    ws[5] = 9'($urandom_range(0, 511));
    hs[5] = 9'($urandom_range(0, 511));
    for (int i = 0; i < 6; i++) begin
      reshape(ws[i], hs[i]);
      tx_steady = (i == 2);
      rx_steady = (i == 2);
      random_traffic(110);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end
  endtask

  // result side held off while beats keep coming, so the input must stall
  task automatic test_input_stall();
    drain_and_idle();
    hold_req  = 1'b1;
    tx_steady = 1'b1;
    repeat (40) sample_at(16'($urandom), 16'($urandom));
    tx_steady = 1'b0;
  endtask

  // result side ready pattern
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        result_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HoldCycles - 1;
        result_bus.ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 99) < 15) begin
        stall_left = pick_stall() - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      got_px = {result_bus.red_out, result_bus.green_out, result_bus.blue_out};
      if (filtered_q.size() == 0) begin
        n_errors++;
        if (n_errors <= ReportMax)
          $display("%0t: result beat with nothing pending: r=%h g=%h b=%h",
                   $time, got_px[2], got_px[1], got_px[0]);
      end else begin
        expected_px = filtered_q.pop_front();
        n_checked++;
        if (got_px[2] !== expected_px[2] || got_px[1] !== expected_px[1] ||
            got_px[0] !== expected_px[0]) begin
          n_errors++;
          if (n_errors <= ReportMax)
            $display("%0t: mismatch expected r=%h g=%h b=%h, got r=%h g=%h b=%h", $time,
                     expected_px[2], expected_px[1], expected_px[0],
                     got_px[2], got_px[1], got_px[0]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 StallLimit, filtered_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_index_i          <= bts_pkg::REG_TEX_WIDTH;
    cfg_data_i           <= '0;
    item_bus.valid       <= 1'b0;
    item_bus.op          <= bts_pkg::OP_WRITE;
    item_bus.texel_index <= '0;
    item_bus.red_in      <= '0;
    item_bus.green_in    <= '0;
    item_bus.blue_in     <= '0;
    item_bus.u_coord     <= '0;
    item_bus.v_coord     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_shape();
    test_tiny_texture();
    test_side_sweep();
    test_input_stall();
    drain_and_idle();

    $display("sent %0d beats (%0d samples, %0d texel writes) over %0d texture shapes",
             n_items, n_samples, n_writes, n_shapes);
    $display("checked %0d filtered results, %0d errors", n_checked, n_errors);
    if (n_errors == 0 && filtered_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
